/* rtl/core/dmac_pkg.sv */
// ----------------------------------------------------------------------------
// dmac_pkg
// Shared types and constants of the multi-channel DMA controller core:
// input modes, result kinds, control bit positions and size helpers.
// ----------------------------------------------------------------------------
package dmac_pkg;

	// input modes
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_REQ   = 2'd2;
	localparam logic [1:0] MODE_RET   = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_READ    = 3'd0;
	localparam logic [2:0] KIND_WRITE   = 3'd1;
	localparam logic [2:0] KIND_FETCH   = 3'd2;
	localparam logic [2:0] KIND_STORE   = 3'd3;
	localparam logic [2:0] KIND_IGNORED = 3'd4;

	// register map
	localparam int REG_BASE  = 8;
	localparam int CH_STRIDE = 20;
	localparam int MAX_CH    = 7;

	localparam logic [9:0] OFF_STATUS = 10'd0;
	localparam logic [9:0] OFF_FLAGS  = 10'd4;

	localparam logic [1:0] REG_CTL  = 2'd0;
	localparam logic [1:0] REG_CNT  = 2'd1;
	localparam logic [1:0] REG_PADR = 2'd2;
	localparam logic [1:0] REG_MADR = 2'd3;

	// control word bits
	localparam int CTL_EN    = 0;
	localparam int CTL_DIR   = 4;
	localparam int CTL_CIRC  = 5;
	localparam int CTL_PINC  = 6;
	localparam int CTL_MINC  = 7;
	localparam int CTL_PSIZE = 8;
	localparam int CTL_MSIZE = 10;

	localparam logic [1:0] SZ_8  = 2'd0;
	localparam logic [1:0] SZ_16 = 2'd1;

	// command from controller to datapath
	typedef struct packed {
		logic exec;
	} dmac_cmd_t;

	// element size in bytes, reserved code counts as 32-bit
	function automatic logic [2:0] size_bytes(input logic [1:0] code);
		case (code)
			SZ_8:    size_bytes = 3'd1;
			SZ_16:   size_bytes = 3'd2;
			default: size_bytes = 3'd4;
		endcase
	endfunction

	function automatic logic [31:0] align_mask(input logic [1:0] code);
		case (code)
			SZ_8:    align_mask = 32'hFFFF_FFFF;
			SZ_16:   align_mask = 32'hFFFF_FFFE;
			default: align_mask = 32'hFFFF_FFFC;
		endcase
	endfunction

	function automatic logic [31:0] keep_mask(input logic [1:0] code);
		case (code)
			SZ_8:    keep_mask = 32'hFFFF_FF00;
			SZ_16:   keep_mask = 32'hFFFF_0000;
			default: keep_mask = 32'h0000_0000;
		endcase
	endfunction

	function automatic logic [31:0] take_mask(input logic [1:0] code);
		case (code)
			SZ_8:    take_mask = 32'h0000_00FF;
			SZ_16:   take_mask = 32'h0000_FFFF;
			default: take_mask = 32'hFFFF_FFFF;
		endcase
	endfunction

endpackage

/* rtl/core/dma_channel_controller_core.sv */
// ----------------------------------------------------------------------------
// dma_channel_controller_core
// Multi-channel DMA controller core: register access and transfer steps.
// ----------------------------------------------------------------------------
// Every accepted transaction (register read, register write, transfer
// request or return of fetched words) yields exactly one result in the
// output register in the next cycle. A new transaction is taken every
// cycle as long as the result of the previous one is taken; the output
// register is the only stage, and all register file work is done in the
// cycle that takes the transaction. The channel count register is written
// through its own cfg channel, which is always ready.
module dma_channel_controller_core
	import dmac_pkg::*;
#(
	parameter int CHANNELS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [9:0]  addr,
	input  logic [31:0] wdata,
	input  logic [2:0]  channel,
	input  logic [31:0] src_word,
	input  logic [31:0] dst_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] rdata,
	output logic [31:0] src_addr,
	output logic [31:0] dst_addr,
	output logic [31:0] store_data
);

	dmac_cmd_t cmd;

	assign cfg_ready = 1'b1;

	// handshake controller
	dmac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// register file and transfer datapath
	dmac_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.mode       (mode),
		.addr       (addr),
		.wdata      (wdata),
		.channel    (channel),
		.src_word   (src_word),
		.dst_word   (dst_word),
		.kind       (kind),
		.rdata      (rdata),
		.src_addr   (src_addr),
		.dst_addr   (dst_addr),
		.store_data (store_data)
	);

endmodule

/* rtl/core/dmac_ctrl.sv */
// ----------------------------------------------------------------------------
// dmac_ctrl
// Handshake controller: tracks whether the output register holds a result
// and tells the datapath when to execute a transaction.
// ----------------------------------------------------------------------------
module dmac_ctrl
	import dmac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output dmac_cmd_t cmd
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_FULL  = 1'b1;

	logic state_q;
	logic state_d;

	// accept whenever the output register is free or being drained
	always_comb begin
		in_ready  = (state_q == ST_EMPTY) || out_ready;
		out_valid = (state_q == ST_FULL);
		cmd.exec  = in_valid && in_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (cmd.exec)
					state_d = ST_FULL;
			end
			ST_FULL: begin
				if (!cmd.exec && out_ready)
					state_d = ST_EMPTY;
			end
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_EMPTY;
		else
			state_q <= state_d;
	end

endmodule

/* rtl/core/dmac_dp.sv */
// ----------------------------------------------------------------------------
// dmac_dp
// Datapath: register file of all channels, address decode, transfer
// request and store logic, pending request tracking and the output register.
// ----------------------------------------------------------------------------
module dmac_dp
	import dmac_pkg::*;
#(
	parameter int CHANNELS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dmac_cmd_t   cmd,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_data,
	input  logic [1:0]  mode,
	input  logic [9:0]  addr,
	input  logic [31:0] wdata,
	input  logic [2:0]  channel,
	input  logic [31:0] src_word,
	input  logic [31:0] dst_word,
	output logic [2:0]  kind,
	output logic [31:0] rdata,
	output logic [31:0] src_addr,
	output logic [31:0] dst_addr,
	output logic [31:0] store_data
);

	logic [2:0]  cfg_q;
	logic [31:0] status_q;
	logic [31:0] flags_q;
	logic [31:0] ctl_q  [CHANNELS];
	logic [31:0] cnt_q  [CHANNELS];
	logic [31:0] rld_q  [CHANNELS];
	logic [31:0] padr_q [CHANNELS];
	logic [31:0] madr_q [CHANNELS];
	logic        pend_valid_q;
	logic [2:0]  pend_ch_q;

	logic [2:0]  live;
	logic [9:0]  rel;
	logic [2:0]  dec_c;
	logic [9:0]  off;
	logic        map_ok;
	logic [1:0]  dec_reg;
	logic [2:0]  sel_ch;
	logic [31:0] s_ctl, s_cnt, s_rld, s_padr, s_madr;
	logic        chan_ok;
	logic [1:0]  psz, msz, ssz, dsz;
	logic        dir;
	logic [31:0] pa_al, ma_al;
	logic        do_store;
	logic        do_fetch;
	logic        do_wr;
	logic [31:0] cnt_dec;
	logic [31:0] cnt_nxt;
	logic [31:0] padr_nxt, madr_nxt;
	logic [2:0]  kind_d;
	logic [31:0] rdata_d, src_d, dst_d, sd_d;

	// number of responding channels
	assign live = (cfg_q < 3'(CHANNELS)) ? cfg_q : 3'(CHANNELS);

	// address decode: channel from a short compare chain, then word offset
	always_comb begin
		rel   = addr - 10'(REG_BASE);
		dec_c = '0;
		for (int k = 1; k <= MAX_CH; k++) begin
			if (rel >= 10'(CH_STRIDE * k))
				dec_c = 3'(k);
		end
		off     = rel - 10'(int'(dec_c) * CH_STRIDE);
		dec_reg = off[3:2];
		map_ok  = (addr >= 10'(REG_BASE)) && (rel < 10'(CH_STRIDE * MAX_CH))
			&& (dec_c < live) && (off[1:0] == 2'b00) && (off <= 10'd12);
	end

	// one channel is addressed per transaction
	always_comb begin
		case (mode)
			MODE_READ, MODE_WRITE: sel_ch = dec_c;
			MODE_REQ:              sel_ch = channel;
			default:               sel_ch = pend_ch_q;
		endcase
	end

	// selected channel registers
	always_comb begin
		s_ctl  = '0;
		s_cnt  = '0;
		s_rld  = '0;
		s_padr = '0;
		s_madr = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (sel_ch == 3'(i)) begin
				s_ctl  = ctl_q[i];
				s_cnt  = cnt_q[i];
				s_rld  = rld_q[i];
				s_padr = padr_q[i];
				s_madr = madr_q[i];
			end
		end
	end

	// transfer step logic
	always_comb begin
		chan_ok  = (sel_ch < live) && s_ctl[CTL_EN] && (s_cnt != '0);
		psz      = s_ctl[CTL_PSIZE +: 2];
		msz      = s_ctl[CTL_MSIZE +: 2];
		dir      = s_ctl[CTL_DIR];
		ssz      = dir ? msz : psz;
		dsz      = dir ? psz : msz;
		pa_al    = s_padr & align_mask(psz);
		ma_al    = s_madr & align_mask(msz);
		do_fetch = (mode == MODE_REQ) && chan_ok;
		do_store = (mode == MODE_RET) && pend_valid_q && chan_ok;
		do_wr    = (mode == MODE_WRITE) && map_ok;
		cnt_dec  = s_cnt - 32'd1;
		cnt_nxt  = ((cnt_dec == '0) && s_ctl[CTL_CIRC]) ? s_rld : cnt_dec;
		padr_nxt = s_ctl[CTL_PINC] ? s_padr + {29'd0, size_bytes(psz)} : s_padr;
		madr_nxt = s_ctl[CTL_MINC] ? s_madr + {29'd0, size_bytes(msz)} : s_madr;
	end

	// result of this transaction
	always_comb begin
		kind_d  = KIND_IGNORED;
		rdata_d = '0;
		src_d   = '0;
		dst_d   = '0;
		sd_d    = '0;
		case (mode)
			MODE_READ: begin
				kind_d = KIND_READ;
				if (addr == OFF_STATUS)
					rdata_d = status_q;
				else if (addr == OFF_FLAGS)
					rdata_d = flags_q;
				else if (map_ok) begin
					case (dec_reg)
						REG_CTL:  rdata_d = s_ctl;
						REG_CNT:  rdata_d = s_cnt;
						REG_PADR: rdata_d = s_padr;
						default:  rdata_d = s_madr;
					endcase
				end
			end
			MODE_WRITE: kind_d = KIND_WRITE;
			MODE_REQ: begin
				if (do_fetch) begin
					kind_d = KIND_FETCH;
					src_d  = dir ? ma_al : pa_al;
					dst_d  = dir ? pa_al : ma_al;
				end
			end
			default: begin
				if (do_store) begin
					kind_d = KIND_STORE;
					dst_d  = dir ? pa_al : ma_al;
					sd_d   = (dst_word & keep_mask(dsz)) | (src_word & take_mask(ssz));
				end
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_q <= 3'(MAX_CH);
		else if (cfg_valid)
			cfg_q <= cfg_data;
	end

	// status words and pending request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= '0;
			flags_q      <= '0;
			pend_valid_q <= 1'b0;
			pend_ch_q    <= '0;
		end else if (cmd.exec) begin
			if (mode == MODE_WRITE && addr == OFF_STATUS)
				status_q <= wdata;
			if (mode == MODE_WRITE && addr == OFF_FLAGS)
				flags_q <= wdata;
			if (do_fetch) begin
				pend_valid_q <= 1'b1;
				pend_ch_q    <= channel;
			end
			if (mode == MODE_RET)
				pend_valid_q <= 1'b0;
		end
	end

	// channel register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				ctl_q[i]  <= '0;
				cnt_q[i]  <= '0;
				rld_q[i]  <= '0;
				padr_q[i] <= '0;
				madr_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (sel_ch == 3'(i)) begin
					if (do_wr) begin
						case (dec_reg)
							REG_CTL: ctl_q[i] <= wdata;
							REG_CNT: begin
								cnt_q[i] <= wdata;
								rld_q[i] <= wdata;
							end
							REG_PADR: padr_q[i] <= wdata;
							default:  madr_q[i] <= wdata;
						endcase
					end
					if (do_store) begin
						cnt_q[i]  <= cnt_nxt;
						padr_q[i] <= padr_nxt;
						madr_q[i] <= madr_nxt;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			kind       <= kind_d;
			rdata      <= rdata_d;
			src_addr   <= src_d;
			dst_addr   <= dst_d;
			store_data <= sd_d;
		end
	end

endmodule

/* rtl/core/dmac_checker.sv */
// ----------------------------------------------------------------------------
// dmac_checker
// Port level checks of the DMA controller core, bound to the top level.
// ----------------------------------------------------------------------------
module dmac_checker
	import dmac_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [31:0] dst_addr,
	input logic [31:0] store_data
);

	// an accepted transaction shows a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted transaction gave no result");

	// no transaction is taken while a stalled result would be overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("transaction accepted over a stalled result");

	// a stalled result holds its kind and data
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(store_data)
			&& $stable(dst_addr))
		else $error("stalled result changed");

	// only store results carry merged data
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_STORE |-> store_data == '0)
		else $error("store data on a non-store result");

endmodule

bind dma_channel_controller_core dmac_checker u_dmac_checker (.*);
